// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define MFB_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== sv/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// Types and constants shared by the framebuffer draw engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mfb_pkg;

  // Width of the signed working coordinates; wide enough for a clipped bar end.
  localparam int CW = 18;

  typedef enum logic [2:0] {
    CMD_PIXEL  = 3'd0,
    CMD_SPRITE = 3'd1,
    CMD_RECT   = 3'd2,
    CMD_BAR    = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    SEG_PIXEL,
    SEG_SPRITE,
    SEG_TOP,
    SEG_BOT,
    SEG_LEFT,
    SEG_RIGHT,
    SEG_FILL
  } seg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SEG_CHK,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_e;

  typedef struct packed {
    logic load;
    logic clear_write;
    logic div_step;
    logic seg_next;
    logic pix_write;
    logic pix_advance;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic seg_empty;
    logic pix_last;
    logic last_seg;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/mono_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Page-organized 1-bit framebuffer with pixel, sprite, outline, bar and read.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                Payload
//   --------  -----------------------  -----------------------------------
//   input     in_valid_i / in_stall_o  command, position, size, ink, sprite,
//                                      mask, column count, level, full scale
//   output    out_valid_o / out_stall_i read_data
//
// After reset the engine clears all FB_WIDTH*ceil(FB_HEIGHT/8) store bytes
// (1024 with the default geometry) and stalls input meanwhile.
// Every drawn pixel is a read-modify-write of its byte through the single RAM
// port, in a read state and then a write state; each segment first passes
// through a check state. Outlines walk w+w+h+h pixels; a bar first runs the
// fill divider (16 quotient bits and a final check) before drawing its outline
// and the clipped fill area.
// A read passes an address state and a data state; its result sits in an
// output register, so the engine accepts further transactions while that
// result waits to be taken, and only a following read waits until the
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_framebuffer_draw_engine import mfb_pkg::*; #(
  parameter int FB_WIDTH  = 128,
  parameter int FB_HEIGHT = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        command_i,
  input  wire logic signed [8:0] pos_x_i,
  input  wire logic signed [8:0] pos_y_i,
  input  wire logic [7:0]        size_w_i,
  input  wire logic [7:0]        size_h_i,
  input  wire logic              ink_i,
  input  wire logic [7:0]        sprite_bits_i,
  input  wire logic [7:0]        mask_bits_i,
  input  wire logic [3:0]        column_count_i,
  input  wire logic [7:0]        level_i,
  input  wire logic [7:0]        level_max_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             read_data_o
);

  // The store holds one byte per column per page of eight rows.
  localparam int Pages = (FB_HEIGHT + 7) / 8;
  localparam int Bytes = FB_WIDTH * Pages;
  localparam int AW    = $clog2(Bytes);

  ctrl_cmd_t     cmd;
  dp_status_t    st;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  // The controller sequences every transaction; of the payload it sees only the command.
  mfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  // The datapath walks the pixels of each segment and modifies store bytes.
  mfb_dp #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .command_i      (command_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .size_w_i       (size_w_i),
    .size_h_i       (size_h_i),
    .ink_i          (ink_i),
    .sprite_bits_i  (sprite_bits_i),
    .mask_bits_i    (mask_bits_i),
    .column_count_i (column_count_i),
    .level_i        (level_i),
    .level_max_i    (level_max_i),
    .cmd_i          (cmd),
    .st_o           (st),
    .ram_we_o       (ram_we),
    .ram_addr_o     (ram_addr),
    .ram_wdata_o    (ram_wdata),
    .ram_rdata_i    (ram_rdata),
    .read_data_o    (read_data_o)
  );

  // Frame store: single port, registered read.
  mfb_ram #(
    .WIDTH (8),
    .DEPTH (Bytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== sv/mfb_ram.sv =====
// ----------------------------------------------------------------------------
// mfb_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/mfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfb_ctrl
// Command sequencer: clearing pass, divider wait, per-pixel read-modify-write, byte read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mfb_ctrl import mfb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] command_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output ctrl_cmd_t       cmd_o,
  input  dp_status_t      st_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_write = 1'b1;
        if (st_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (command_i)
            CMD_PIXEL, CMD_SPRITE, CMD_RECT: state_d = ST_SEG_CHK;
            CMD_BAR:                         state_d = ST_DIV;
            CMD_READ:                        state_d = ST_RD_ADDR;
            default:                         state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (st_i.div_done) begin
          state_d = ST_SEG_CHK;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_SEG_CHK: begin
        if (!st_i.seg_empty) begin
          state_d = ST_PIX_RD;
        end else if (st_i.last_seg) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.seg_next = 1'b1;
        end
      end
      ST_PIX_RD: begin
        state_d = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        cmd_o.pix_write = 1'b1;
        if (!st_i.pix_last) begin
          cmd_o.pix_advance = 1'b1;
          state_d = ST_PIX_RD;
        end else if (st_i.last_seg) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.seg_next = 1'b1;
          state_d = ST_SEG_CHK;
        end
      end
      ST_RD_ADDR: begin
        state_d = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `MFB_ASSERT(a_result_from_read, $rose(out_valid_q) |-> $past(state_q) == ST_RD_DATA,
              "result appeared without a read transaction")
  `MFB_ASSERT(a_write_after_read, state_q == ST_PIX_WR |-> $past(state_q) == ST_PIX_RD,
              "pixel write without a preceding byte read")
  `MFB_ASSERT(a_div_holds, state_q == ST_DIV && !st_i.div_done |=> state_q == ST_DIV,
              "left the divider before the quotient was ready")

endmodule

`default_nettype wire

// ===== sv/mfb_dp.sv =====
// ----------------------------------------------------------------------------
// mfb_dp
// Datapath: command fields, segment walker, fill divider, byte modify, output.
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_dp import mfb_pkg::*; #(
  parameter int FB_WIDTH  = 128,
  parameter int FB_HEIGHT = 64,
  localparam int Pages    = (FB_HEIGHT + 7) / 8,
  localparam int Bytes    = FB_WIDTH * Pages,
  localparam int AW       = $clog2(Bytes)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [2:0]        command_i,
  input  wire logic signed [8:0] pos_x_i,
  input  wire logic signed [8:0] pos_y_i,
  input  wire logic [7:0]        size_w_i,
  input  wire logic [7:0]        size_h_i,
  input  wire logic              ink_i,
  input  wire logic [7:0]        sprite_bits_i,
  input  wire logic [7:0]        mask_bits_i,
  input  wire logic [3:0]        column_count_i,
  input  wire logic [7:0]        level_i,
  input  wire logic [7:0]        level_max_i,
  input  ctrl_cmd_t              cmd_i,
  output dp_status_t             st_o,
  output logic                   ram_we_o,
  output logic [AW-1:0]          ram_addr_o,
  output logic [7:0]             ram_wdata_o,
  input  wire logic [7:0]        ram_rdata_i,
  output logic [7:0]             read_data_o
);

  localparam logic signed [CW-1:0] WS = CW'(FB_WIDTH);
  localparam logic signed [CW-1:0] HS = CW'(FB_HEIGHT);
  localparam logic signed [CW-1:0] One = CW'(1);

  // Latched command fields.
  logic signed [8:0] x_q, y_q;
  logic [7:0] w_q, h_q, spr_q, msk_q, lmax_q, cnt_q;
  logic [3:0] cols_q;
  logic       ink_q, bar_q;
  seg_e       seg_q;
  logic signed [CW-1:0] fx_q, fy_q;

  // Divider state.
  logic [15:0] quo_q;
  logic [7:0]  rem_q;
  logic [4:0]  div_cnt_q;
  logic [8:0]  trial;

  logic [AW-1:0] clr_q;
  logic [7:0]    read_data_q;

  // Derived coordinates.
  logic signed [CW-1:0] sx, sy, wz, hz, cz, qz;
  logic signed [CW-1:0] fx0, fx_lim, fx_end, fy0, fy_lim, fy_end;
  logic signed [CW-1:0] px, py;
  logic [3:0]  sp_len;
  logic [2:0]  sp_idx;
  logic        en, color, on, live, fill_ok;
  logic [31:0] addr_w;
  logic [7:0]  bit_mask, modified;
  seg_e        seg_nxt;

  assign sx = CW'(x_q);
  assign sy = CW'(y_q);
  assign wz = $signed({{(CW-8){1'b0}}, w_q});
  assign hz = $signed({{(CW-8){1'b0}}, h_q});
  assign cz = $signed({{(CW-8){1'b0}}, cnt_q});
  assign qz = $signed({{(CW-16){1'b0}}, quo_q});

  // Fill window, clipped to the display.
  assign fx0     = (sx + One < 0) ? '0 : sx + One;
  assign fx_lim  = sx + One + qz;
  assign fx_end  = (fx_lim > WS) ? WS : fx_lim;
  assign fy0     = (sy + One < 0) ? '0 : sy + One;
  assign fy_lim  = sy + hz - One;
  assign fy_end  = (fy_lim > HS) ? HS : fy_lim;
  assign fill_ok = (lmax_q != 8'd0) && (quo_q != 16'd0) && (fx0 < fx_end) && (fy0 < fy_end);

  assign sp_len = (cols_q > 4'd8) ? 4'd8 : cols_q;
  assign sp_idx = 3'd7 - cnt_q[2:0];

  always_comb begin
    px         = sx;
    py         = sy;
    en         = 1'b1;
    color      = bar_q | ink_q;
    st_o       = '0;
    seg_nxt    = SEG_FILL;
    case (seg_q)
      SEG_PIXEL: begin
        st_o.pix_last = 1'b1;
        st_o.last_seg = 1'b1;
      end
      SEG_SPRITE: begin
        px             = sx + cz;
        en             = msk_q[sp_idx];
        color          = spr_q[sp_idx];
        st_o.seg_empty = (sp_len == 4'd0);
        st_o.pix_last  = (cnt_q == {4'd0, sp_len} - 8'd1);
        st_o.last_seg  = 1'b1;
      end
      SEG_TOP: begin
        px             = sx + cz;
        st_o.seg_empty = (w_q == 8'd0);
        st_o.pix_last  = (cnt_q == w_q - 8'd1);
        seg_nxt        = SEG_BOT;
      end
      SEG_BOT: begin
        px             = sx + cz;
        py             = sy + hz - One;
        st_o.seg_empty = (w_q == 8'd0);
        st_o.pix_last  = (cnt_q == w_q - 8'd1);
        seg_nxt        = SEG_LEFT;
      end
      SEG_LEFT: begin
        py             = sy + cz;
        st_o.seg_empty = (h_q == 8'd0);
        st_o.pix_last  = (cnt_q == h_q - 8'd1);
        seg_nxt        = SEG_RIGHT;
      end
      SEG_RIGHT: begin
        px             = sx + wz - One;
        py             = sy + cz;
        st_o.seg_empty = (h_q == 8'd0);
        st_o.pix_last  = (cnt_q == h_q - 8'd1);
        st_o.last_seg  = !bar_q;
      end
      SEG_FILL: begin
        px             = fx_q;
        py             = fy_q;
        st_o.seg_empty = !fill_ok;
        st_o.pix_last  = (fx_q == fx_end - One) && (fy_q == fy_end - One);
        st_o.last_seg  = 1'b1;
      end
      default: begin
        st_o.seg_empty = 1'b1;
        st_o.last_seg  = 1'b1;
      end
    endcase
    st_o.clear_last = (clr_q == AW'(Bytes - 1));
    st_o.div_done   = (div_cnt_q == 5'd0);
  end

  assign on   = !px[CW-1] && (px < WS) && !py[CW-1] && (py < HS);
  assign live = on && en;

  assign addr_w   = 32'(py[CW-1:3]) * 32'(FB_WIDTH) + 32'(px);
  assign bit_mask = 8'd1 << py[2:0];
  assign modified = color ? (ram_rdata_i | bit_mask) : (ram_rdata_i & ~bit_mask);

  assign ram_we_o    = cmd_i.clear_write || (cmd_i.pix_write && live);
  assign ram_wdata_o = cmd_i.clear_write ? 8'd0 : modified;
  assign ram_addr_o  = cmd_i.clear_write ? clr_q : addr_w[AW-1:0];

  assign trial = {rem_q, quo_q[15]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_write) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q       <= pos_x_i;
      y_q       <= pos_y_i;
      w_q       <= size_w_i;
      h_q       <= size_h_i;
      ink_q     <= ink_i;
      spr_q     <= sprite_bits_i;
      msk_q     <= mask_bits_i;
      cols_q    <= column_count_i;
      lmax_q    <= level_max_i;
      bar_q     <= (command_i == CMD_BAR);
      cnt_q     <= 8'd0;
      rem_q     <= 8'd0;
      div_cnt_q <= 5'd16;
      quo_q     <= (size_w_i >= 8'd3) ? {8'd0, level_i} * {8'd0, size_w_i - 8'd2} : 16'd0;
      case (command_i)
        CMD_SPRITE:       seg_q <= SEG_SPRITE;
        CMD_RECT, CMD_BAR: seg_q <= SEG_TOP;
        default:          seg_q <= SEG_PIXEL;
      endcase
    end
    if (cmd_i.div_step) begin
      if (trial >= {1'b0, lmax_q}) begin
        rem_q <= 8'(trial - {1'b0, lmax_q});
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= trial[7:0];
        quo_q <= {quo_q[14:0], 1'b0};
      end
      div_cnt_q <= div_cnt_q - 5'd1;
    end
    if (cmd_i.seg_next) begin
      seg_q <= seg_nxt;
      cnt_q <= 8'd0;
      fx_q  <= fx0;
      fy_q  <= fy0;
    end
    if (cmd_i.pix_advance) begin
      cnt_q <= cnt_q + 8'd1;
      if (fx_q == fx_end - One) begin
        fx_q <= fx0;
        fy_q <= fy_q + One;
      end else begin
        fx_q <= fx_q + One;
      end
    end
    if (cmd_i.out_load) begin
      read_data_q <= on ? ram_rdata_i : 8'd0;
    end
  end

  assign read_data_o = read_data_q;

endmodule

`default_nettype wire

// ===== tb/mono_framebuffer_draw_engine_tb.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_tb
// Drives drawing commands and byte reads through the engine. A local copy of
// the framebuffer works out every read, and the monitor checks each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mono_framebuffer_draw_engine_tb;
  import mfb_pkg::*;

  localparam int FB_WIDTH  = 128;
  localparam int FB_HEIGHT = 64;
  localparam int FB_BYTES  = FB_WIDTH * ((FB_HEIGHT + 7) / 8);

  // One drawing transaction, at the port widths.
  typedef struct {
    logic [2:0]        command;
    logic signed [8:0] pos_x;
    logic signed [8:0] pos_y;
    logic [7:0]        size_w;
    logic [7:0]        size_h;
    logic              ink;
    logic [7:0]        sprite_bits;
    logic [7:0]        mask_bits;
    logic [3:0]        column_count;
    logic [7:0]        level;
    logic [7:0]        level_max;
    bit                drain_before;  // sender waits until every read has returned
  } draw_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] command_i = '0;
  logic signed [8:0] pos_x_i = '0;
  logic signed [8:0] pos_y_i = '0;
  logic [7:0] size_w_i = '0;
  logic [7:0] size_h_i = '0;
  logic ink_i = 1'b0;
  logic [7:0] sprite_bits_i = '0;
  logic [7:0] mask_bits_i = '0;
  logic [3:0] column_count_i = '0;
  logic [7:0] level_i = '0;
  logic [7:0] level_max_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] read_data_o;

  mono_framebuffer_draw_engine #(
    .FB_WIDTH (FB_WIDTH),
    .FB_HEIGHT(FB_HEIGHT)
  ) DUT (.*);

  always #5 clk_i = ~clk_i;

  // Shadow framebuffer and the read bytes still to come back.
  logic [7:0] shadow_fb [FB_BYTES];
  logic [7:0] read_bytes_due [$];
  draw_item_t pending_items [$];
  int mismatch_count = 0;
  bit stimulus_done = 1'b0;
  int hold_off_cycles = 0;  // long receiver hold-off, counted down by the monitor

  // ---------------------------------------------------------------------------
  // Shadow drawing. Pixels off the display are dropped.
  // ---------------------------------------------------------------------------
  function automatic void shadow_plot(int x, int y, bit color);
    int idx;
    if (x < 0 || x >= FB_WIDTH || y < 0 || y >= FB_HEIGHT) return;
    idx = (y / 8) * FB_WIDTH + x;
    shadow_fb[idx][y % 8] = color;
  endfunction

  function automatic void shadow_outline(int x, int y, int w, int h, bit color);
    for (int i = x; i < x + w; i++) begin
      shadow_plot(i, y, color);
      shadow_plot(i, y + h - 1, color);
    end
    for (int i = y; i < y + h; i++) begin
      shadow_plot(x, i, color);
      shadow_plot(x + w - 1, i, color);
    end
  endfunction

  // Applies one transaction; a read pushes the byte that must come back.
  function automatic void shadow_apply(draw_item_t it);
    int x, y, w, h, cnt, fill, x_end;
    x = it.pos_x;
    y = it.pos_y;
    w = it.size_w;
    h = it.size_h;
    case (it.command)
      CMD_PIXEL: shadow_plot(x, y, it.ink);
      CMD_SPRITE: begin
        cnt = (it.column_count > 8) ? 8 : it.column_count;
        for (int sx = 0; sx < cnt; sx++)
          if (it.mask_bits[7 - sx]) shadow_plot(x + sx, y, it.sprite_bits[7 - sx]);
      end
      CMD_RECT: shadow_outline(x, y, w, h, it.ink);
      CMD_BAR: begin
        shadow_outline(x, y, w, h, 1'b1);
        // The fill may run past the border when the level tops the full scale.
        if (it.level_max != 0 && w - 2 > 0 && it.level > 0) begin
          fill = (int'(it.level) * (w - 2)) / int'(it.level_max);
          if (fill > 0) begin
            x_end = x + 1 + fill;
            if (x_end > FB_WIDTH) x_end = FB_WIDTH;
            for (int py = y + 1; py < y + h - 1; py++)
              for (int px = x + 1; px < x_end; px++) shadow_plot(px, py, 1'b1);
          end
        end
      end
      CMD_READ: begin
        if (x >= 0 && x < FB_WIDTH && y >= 0 && y < FB_HEIGHT)
          read_bytes_due.push_back(shadow_fb[(y / 8) * FB_WIDTH + x]);
        else
          read_bytes_due.push_back(8'h00);
      end
      default: ;  // Unused codes draw nothing.
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders. Most shapes stay small so that the run remains short.
  // ---------------------------------------------------------------------------
  function automatic draw_item_t make_item(logic [2:0] cmd);
    draw_item_t it;
    it.command      = cmd;
    it.pos_x        = 9'($urandom);
    it.pos_y        = 9'($urandom);
    it.size_w       = 8'($urandom);
    it.size_h       = 8'($urandom);
    it.ink          = 1'($urandom);
    it.sprite_bits  = 8'($urandom);
    it.mask_bits    = 8'($urandom);
    it.column_count = 4'($urandom);
    it.level        = 8'($urandom);
    it.level_max    = 8'($urandom);
    it.drain_before = 1'b0;
    return it;
  endfunction

  // Random item with coordinates mostly near the display and small shapes.
  function automatic draw_item_t random_item();
    draw_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      it = make_item(CMD_PIXEL);
    else if (pick < 45) it = make_item(CMD_SPRITE);
    else if (pick < 55) it = make_item(CMD_RECT);
    else if (pick < 63) it = make_item(CMD_BAR);
    else if (pick < 98) it = make_item(CMD_READ);
    else                it = make_item(3'($urandom_range(5, 7)));
    if ($urandom_range(0, 9) != 0) begin
      it.pos_x = $signed(9'($urandom_range(0, FB_WIDTH + 7))) - 9'sd4;
      it.pos_y = $signed(9'($urandom_range(0, FB_HEIGHT + 7))) - 9'sd4;
    end
    if ($urandom_range(0, 19) != 0) begin
      it.size_w = 8'($urandom_range(0, 24));
      it.size_h = 8'($urandom_range(0, 12));
    end
    if ($urandom_range(0, 3) != 0) it.column_count = 4'($urandom_range(1, 8));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued transactions with random gaps. The offered
  // transaction stays at the front of the queue until it is taken.
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (!(in_valid_i && in_stall_o)) begin
        // Previous transaction taken, or nothing offered.
        if (in_valid_i) void'(pending_items.pop_front());
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pending_items.size() != 0
                     && !(pending_items[0].drain_before && read_bytes_due.size() != 0)) begin
          draw_item_t it;
          it = pending_items[0];
          pending_items[0].drain_before = 1'b0;
          shadow_apply(it);
          in_valid_i     <= 1'b1;
          command_i      <= it.command;
          pos_x_i        <= it.pos_x;
          pos_y_i        <= it.pos_y;
          size_w_i       <= it.size_w;
          size_h_i       <= it.size_h;
          ink_i          <= it.ink;
          sprite_bits_i  <= it.sprite_bits;
          mask_bits_i    <= it.mask_bits;
          column_count_i <= it.column_count;
          level_i        <= it.level;
          level_max_i    <= it.level_max;
          if ($urandom_range(0, 2) == 0)
            gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stalls, long hold-offs on request, and the byte checks.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (read_bytes_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected read result: actual %02h", read_data_o);
        end else begin
          logic [7:0] want;
          want = read_bytes_due.pop_front();
          if (want !== read_data_o) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("read_data mismatch: expected %02h actual %02h", want, read_data_o);
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_stall_i     <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    draw_item_t it;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extremes, every command and the special cases.
    it = make_item(CMD_PIXEL); it.pos_x = 0; it.pos_y = 0; it.ink = 1;
    pending_items.push_back(it);
    it = make_item(CMD_PIXEL); it.pos_x = 127; it.pos_y = 63; it.ink = 1;
    pending_items.push_back(it);
    it = make_item(CMD_PIXEL); it.pos_x = -256; it.pos_y = 255; it.ink = 1;
    pending_items.push_back(it);
    it = make_item(CMD_READ); it.pos_x = 0; it.pos_y = 0; pending_items.push_back(it);
    it = make_item(CMD_READ); it.pos_x = 127; it.pos_y = 63; pending_items.push_back(it);
    // Read off the display returns zero.
    it = make_item(CMD_READ); it.pos_x = -1; it.pos_y = 64; pending_items.push_back(it);
    // Sprite with full and clipped counts, zero count and an oversized count.
    it = make_item(CMD_SPRITE); it.pos_x = 10; it.pos_y = 9; it.sprite_bits = 8'hA5;
    it.mask_bits = 8'hFF; it.column_count = 8; pending_items.push_back(it);
    it = make_item(CMD_SPRITE); it.pos_x = 124; it.pos_y = 9; it.sprite_bits = 8'h00;
    it.mask_bits = 8'h3C; it.column_count = 15; pending_items.push_back(it);
    it = make_item(CMD_SPRITE); it.pos_x = 40; it.pos_y = 9; it.column_count = 0;
    pending_items.push_back(it);
    it = make_item(CMD_READ); it.pos_x = 12; it.pos_y = 9; pending_items.push_back(it);
    // Outlines: normal, zero width with height, clipped.
    it = make_item(CMD_RECT); it.pos_x = 20; it.pos_y = 20; it.size_w = 10;
    it.size_h = 6; it.ink = 1; pending_items.push_back(it);
    it = make_item(CMD_RECT); it.pos_x = 50; it.pos_y = 30; it.size_w = 0;
    it.size_h = 5; it.ink = 1; pending_items.push_back(it);
    it = make_item(CMD_RECT); it.pos_x = -3; it.pos_y = 60; it.size_w = 8;
    it.size_h = 8; it.ink = 1; pending_items.push_back(it);
    it = make_item(CMD_READ); it.pos_x = 49; it.pos_y = 31; pending_items.push_back(it);
    // Bars: normal, zero full scale, zero level, narrow, level above full scale.
    it = make_item(CMD_BAR); it.pos_x = 60; it.pos_y = 40; it.size_w = 20;
    it.size_h = 6; it.level = 5; it.level_max = 10; pending_items.push_back(it);
    it = make_item(CMD_BAR); it.pos_x = 0; it.pos_y = 48; it.size_w = 12;
    it.size_h = 5; it.level = 5; it.level_max = 0; pending_items.push_back(it);
    it = make_item(CMD_BAR); it.pos_x = 30; it.pos_y = 48; it.size_w = 12;
    it.size_h = 5; it.level = 0; it.level_max = 9; pending_items.push_back(it);
    it = make_item(CMD_BAR); it.pos_x = 45; it.pos_y = 48; it.size_w = 2;
    it.size_h = 5; it.level = 9; it.level_max = 9; pending_items.push_back(it);
    it = make_item(CMD_BAR); it.pos_x = 100; it.pos_y = 2; it.size_w = 10;
    it.size_h = 5; it.level = 255; it.level_max = 1; pending_items.push_back(it);
    it = make_item(CMD_READ); it.pos_x = 127; it.pos_y = 4; pending_items.push_back(it);
    // Unused command code, then a read of a byte in the first bar's fill.
    it = make_item(3'd7); it.pos_x = 5; it.pos_y = 5; pending_items.push_back(it);
    it = make_item(CMD_READ); it.pos_x = 65; it.pos_y = 42; pending_items.push_back(it);
    // One largest shape, in ink 0, placed wholly off the display.
    it = make_item(CMD_RECT); it.pos_x = -256; it.pos_y = -256; it.size_w = 255;
    it.size_h = 255; it.ink = 0; pending_items.push_back(it);

    // Random part, with one receiver hold-off and two drain pauses partway.
    for (int n = 0; n < 1800; n++) begin
      it = random_item();
      if (n == 600 || n == 1200) it.drain_before = 1'b1;
      pending_items.push_back(it);
      if (n == 300) begin
        while (pending_items.size() > 50) @(posedge clk_i);
        hold_off_cycles = 800;
      end
    end

    while (pending_items.size() != 0) @(posedge clk_i);
    while (read_bytes_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && read_bytes_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Outer limit: clearing pass plus the slowest shapes with every stall.
  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    for (int i = 0; i < FB_BYTES; i++) shadow_fb[i] = 8'h00;
  end

endmodule
